FILE: hw/rtl/prq_pkg.sv
// prq_pkg: shared constants, codes and types of the priority ready queue.
// Used by prq_store, prq_ctrl and priority_ready_queue; no dependencies.
package prq_pkg;

  localparam int DEPTH    = 16;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic              strobe;
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

endpackage

FILE: hw/rtl/prq_store.sv
// prq_store: slot memory of the queue, slot 0 is the head.
// One write port, one read port with registered read data. Uses prq_pkg.
module prq_store (
  input  logic              clk,
  input  prq_pkg::mem_req_t req,
  output prq_pkg::entry_t   rd_data
);
  import prq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

FILE: hw/rtl/prq_ctrl.sv
// prq_ctrl: sequencer of the queue; walks the slot memory one entry per
// step through a single priority comparator. Uses prq_pkg.
module prq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       mode,
  input  logic [prq_pkg::ID_W-1:0]   task_id,
  input  logic [prq_pkg::PRIO_W-1:0] prio,
  input  prq_pkg::entry_t            rd_data,
  output logic                       busy,
  output prq_pkg::mem_req_t          req,
  output prq_pkg::result_t           res
);
  import prq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERD,
    S_ECMP,
    S_ELAST,
    S_DRD,
    S_DHEAD,
    S_DRDM,
    S_DMOVE
  } state_t;

  state_t        state;
  logic [CW-1:0] fill;
  logic [CW-1:0] cur;
  logic [AW-1:0] rd_addr;
  entry_t        new_entry;

  logic          accept;
  logic          lower;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] fill_dec;

  assign accept   = start && !busy;
  // shared compare unit: stored entry ranks strictly below the new one
  assign lower    = rd_data.prio < new_entry.prio;
  assign fill_inc = fill + CW'(1);
  assign fill_dec = fill - CW'(1);

  always_comb begin
    req.wr_en   = 1'b0;
    req.wr_addr = '0;
    req.wr_data = new_entry;
    req.rd_addr = rd_addr;
    case (state)
      S_IDLE: begin
        if (accept && mode == MODE_ENQ && fill == '0) begin
          req.wr_en   = 1'b1;
          req.wr_data = '{prio: prio, id: task_id};
        end
      end
      S_ECMP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = cur[AW-1:0];
        req.wr_data = lower ? rd_data : new_entry;
      end
      S_ELAST: begin
        req.wr_en = 1'b1;
      end
      S_DMOVE: begin
        req.wr_en   = 1'b1;
        req.wr_addr = AW'(cur - CW'(1));
        req.wr_data = rd_data;
      end
      default: begin
        req.wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      busy       <= 1'b0;
      fill       <= '0;
      res.strobe <= 1'b0;
    end else begin
      res.strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            new_entry <= '{prio: prio, id: task_id};
            res.id    <= '0;
            res.prio  <= '0;
            if (mode == MODE_ENQ) begin
              if (fill == CW'(DEPTH)) begin
                res.strobe    <= 1'b1;
                res.status    <= ST_FULL;
                res.occupancy <= OCC_W'(fill);
              end else if (fill == '0) begin
                fill          <= fill_inc;
                res.strobe    <= 1'b1;
                res.status    <= ST_OK;
                res.occupancy <= OCC_W'(fill_inc);
              end else begin
                cur     <= fill;
                rd_addr <= AW'(fill_dec);
                busy    <= 1'b1;
                state   <= S_ERD;
              end
            end else begin
              if (fill == '0) begin
                res.strobe    <= 1'b1;
                res.status    <= ST_EMPTY;
                res.occupancy <= '0;
              end else begin
                rd_addr <= '0;
                busy    <= 1'b1;
                state   <= S_DRD;
              end
            end
          end
        end
        S_ERD: begin
          state <= S_ECMP;
        end
        S_ECMP: begin
          if (lower) begin
            if (cur == CW'(1)) begin
              state <= S_ELAST;
            end else begin
              cur     <= cur - CW'(1);
              rd_addr <= AW'(cur - CW'(2));
              state   <= S_ERD;
            end
          end else begin
            fill          <= fill_inc;
            res.strobe    <= 1'b1;
            res.status    <= ST_OK;
            res.occupancy <= OCC_W'(fill_inc);
            busy          <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_ELAST: begin
          fill          <= fill_inc;
          res.strobe    <= 1'b1;
          res.status    <= ST_OK;
          res.occupancy <= OCC_W'(fill_inc);
          busy          <= 1'b0;
          state         <= S_IDLE;
        end
        S_DRD: begin
          state <= S_DHEAD;
        end
        S_DHEAD: begin
          res.id   <= rd_data.id;
          res.prio <= rd_data.prio;
          if (fill == CW'(1)) begin
            fill          <= fill_dec;
            res.strobe    <= 1'b1;
            res.status    <= ST_OK;
            res.occupancy <= OCC_W'(fill_dec);
            busy          <= 1'b0;
            state         <= S_IDLE;
          end else begin
            cur     <= CW'(1);
            rd_addr <= AW'(1);
            state   <= S_DRDM;
          end
        end
        S_DRDM: begin
          state <= S_DMOVE;
        end
        S_DMOVE: begin
          if (cur == fill_dec) begin
            fill          <= fill_dec;
            res.strobe    <= 1'b1;
            res.status    <= ST_OK;
            res.occupancy <= OCC_W'(fill_dec);
            busy          <= 1'b0;
            state         <= S_IDLE;
          end else begin
            cur     <= cur + CW'(1);
            rd_addr <= AW'(cur + CW'(1));
            state   <= S_DRDM;
          end
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/priority_ready_queue.sv
// Priority ready queue of task ids, highest priority at the head, FIFO order
// within one priority. A command is taken when start is high and busy is low;
// its single result appears for one cycle with strobe and cannot be stalled.
// An enqueue on a full or empty queue and a dequeue on an empty queue answer
// from idle and never raise busy. Other enqueues shift each lower-priority
// entry, tail first, one slot toward the tail and write the new entry into
// the freed slot; a dequeue reads the head, then shifts each later entry one
// slot toward the head. Each shift step waits for the registered read data of
// the single slot memory. busy drops in the cycle the result is shown, so the
// next command may be taken then. Depends on prq_pkg, prq_store, prq_ctrl.
module priority_ready_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [prq_pkg::ID_W-1:0]     task_id,
  input  logic [prq_pkg::PRIO_W-1:0]   prio,
  output logic                         strobe,
  output logic [prq_pkg::STATUS_W-1:0] status,
  output logic [prq_pkg::ID_W-1:0]     out_id,
  output logic [prq_pkg::PRIO_W-1:0]   out_prio,
  output logic [prq_pkg::OCC_W-1:0]    occupancy
);
  import prq_pkg::*;

  mem_req_t req;
  entry_t   rd_data;
  result_t  res;

  prq_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  prq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mode    (mode),
    .task_id (task_id),
    .prio    (prio),
    .rd_data (rd_data),
    .busy    (busy),
    .req     (req),
    .res     (res)
  );

  assign strobe    = res.strobe;
  assign status    = res.status;
  assign out_id    = res.id;
  assign out_prio  = res.prio;
  assign occupancy = res.occupancy;

`ifndef SYNTHESIS
  // every accepted beat is either answered at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || strobe)
    else $error("accepted beat neither answered nor in progress");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result shown while still busy");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_EMPTY |-> occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_OK |-> out_id == '0 && out_prio == '0)
    else $error("error status with nonzero payload");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_FULL |-> occupancy == OCC_W'(DEPTH))
    else $error("full status with occupancy below depth");
`endif

endmodule
